FILE: rtl/ace_pkg.sv
package ace_pkg;

	localparam int FIELD_W       = 26;
	localparam int MAX_DEPS_DEF  = 64;
	localparam int NUM_ATTRS_DEF = 26;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Token handed from cell to cell. For a load, a carries the left set and
	// b the right set; for a query, a carries the closure built so far.
	typedef struct packed {
		logic               present;
		logic               is_load;
		logic               pending;
		logic               grew;
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
	} tok_t;

endpackage

FILE: rtl/ace_cell.sv
module ace_cell import ace_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  tok_t tok_in,
	output tok_t tok_out
);

	logic [FIELD_W-1:0] left_q;
	logic [FIELD_W-1:0] right_q;
	logic               valid_q;
	tok_t               tok_q;
	tok_t               nxt;
	logic               hit;
	logic               covers;
	logic               wr;

	always_comb begin
		hit    = valid_q && (left_q == tok_in.a);
		covers = valid_q && ((left_q & ~tok_in.a) == '0);
		wr     = tok_in.present && tok_in.is_load && tok_in.pending && (hit || !valid_q);
		nxt    = tok_in;
		if (tok_in.is_load) begin
			// A load is settled by the first cell that matches or is free.
			nxt.pending = tok_in.pending && valid_q && !hit;
		end else if (covers) begin
			nxt.a    = tok_in.a | right_q;
			nxt.grew = tok_in.grew | ((right_q & ~tok_in.a) != '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= nxt;
			if (wr) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			left_q  <= tok_in.a;
			right_q <= tok_in.b;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: rtl/attribute_closure_engine_core.sv
// Functional dependency table with attribute closure queries.
// Input: an item is taken at a clock edge where start is high and busy is low.
// cmd selects a load (lhs_mask, rhs_mask) or a query (query_mask).
// Output: one result per item, on closure_mask, is_superkey and table_overflow,
// valid for the single cycle in which done is high. The receiver cannot stall.
// Configuration: attribute_set is written through cfg_valid/cfg_ready/cfg_data,
// with cfg_ready always high; write it only while the block is idle.
// The dependencies sit in a row of MAX_DEPS cells, and every item travels
// along the row as a token, one cell per cycle.
// A load makes one pass along the row, and done is registered from the token
// leaving the last cell. A query makes P passes along the row, where P is one
// more than the number of passes in which the closure grew, so between 1 and
// min(NUM_ATTRS, 26) + 1; done is registered as the token ends its last pass.
// One item is in flight at a time; busy is high from acceptance until done rises,
// so the next item can be taken at the earliest in the cycle in which done is high.
// Reset empties the table and sets attribute_set to all ones.
module attribute_closure_engine_core import ace_pkg::*; #(
	parameter int MAX_DEPS  = MAX_DEPS_DEF,
	parameter int NUM_ATTRS = NUM_ATTRS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cmd,
	input  logic [FIELD_W-1:0] lhs_mask,
	input  logic [FIELD_W-1:0] rhs_mask,
	input  logic [FIELD_W-1:0] query_mask,
	output logic               done,
	output logic [FIELD_W-1:0] closure_mask,
	output logic               is_superkey,
	output logic               table_overflow,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [FIELD_W-1:0] cfg_data
);

	localparam logic [FIELD_W-1:0] AttrMask = (NUM_ATTRS >= FIELD_W) ? {FIELD_W{1'b1}}
		: FIELD_W'((64'd1 << NUM_ATTRS) - 64'd1);

	tok_t               tok [MAX_DEPS+1];
	tok_t               tail;
	logic [MAX_DEPS-1:0] present_vec;
	logic               start_acc;
	logic               again;
	logic               finish;
	logic               busy_q;
	logic               done_q;
	logic [FIELD_W-1:0] closure_q;
	logic               superkey_q;
	logic               overflow_q;
	logic [FIELD_W-1:0] attr_q;

	assign tail      = tok[MAX_DEPS];
	assign start_acc = start && !busy_q;
	// A query goes round again after any pass in which the closure grew.
	assign again     = tail.present && !tail.is_load && tail.grew;
	assign finish    = tail.present && !again;

	always_comb begin
		tok[0].present = start_acc || again;
		tok[0].is_load = start_acc && (cmd == CMD_LOAD);
		tok[0].pending = 1'b1;
		tok[0].grew    = 1'b0;
		tok[0].b       = rhs_mask & AttrMask;
		if (start_acc) begin
			tok[0].a = ((cmd == CMD_LOAD) ? lhs_mask : query_mask) & AttrMask;
		end else begin
			tok[0].a = tail.a;
		end
	end

	for (genvar i = 0; i < MAX_DEPS; i++) begin : g_cell
		ace_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
		assign present_vec[i] = tok[i+1].present;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			attr_q <= {FIELD_W{1'b1}};
		end else begin
			done_q <= finish;
			if (start_acc) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				attr_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			closure_q  <= tail.is_load ? '0 : tail.a;
			superkey_q <= !tail.is_load && ((attr_q & ~tail.a) == '0);
			overflow_q <= tail.is_load && tail.pending;
		end
	end

	assign busy           = busy_q;
	assign done           = done_q;
	assign closure_mask   = closure_q;
	assign is_superkey    = superkey_q;
	assign table_overflow = overflow_q;
	assign cfg_ready      = 1'b1;

`ifndef SYNTH
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(present_vec) <= 1)
		else $error("more than one item travelling along the cells");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result given while still busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_overflow_load: assert property (@(posedge clk) disable iff (!arst_n)
		(done && table_overflow) |-> (closure_mask == '0 && !is_superkey))
		else $error("overflow flagged on a query result");
`endif

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import ace_pkg::*;

	localparam int          TABLE_DEPTH     = MAX_DEPS_DEF;
	localparam int          N_DIRECTED      = 19;
	localparam int          N_PHASES        = 8;
	localparam int          ITEMS_PER_PHASE = 210;
	localparam longint      CYCLE_LIMIT     = 12_000_000;
	localparam logic [FIELD_W-1:0] ALL_ATTRS = {FIELD_W{1'b1}};
	localparam logic [FIELD_W-1:0] NO_ATTRS  = '0;

	typedef struct packed {
		logic               cmd;
		logic [FIELD_W-1:0] lhs;
		logic [FIELD_W-1:0] rhs;
		logic [FIELD_W-1:0] qry;
	} item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] closure;
		logic               superkey;
		logic               overflow;
	} result_t;

	typedef struct packed {
		logic    typed;
		item_t   it;
		result_t want;
	} dir_row_t;

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               start      = 1'b0;
	logic               cmd        = CMD_LOAD;
	logic [FIELD_W-1:0] lhs_mask   = '0;
	logic [FIELD_W-1:0] rhs_mask   = '0;
	logic [FIELD_W-1:0] query_mask = '0;
	logic               cfg_valid  = 1'b0;
	logic [FIELD_W-1:0] cfg_data   = '0;
	logic               busy;
	logic               done;
	logic [FIELD_W-1:0] closure_mask;
	logic               is_superkey;
	logic               table_overflow;
	logic               cfg_ready;

	// Own copy of the dependency table and of the attribute set register.
	logic [FIELD_W-1:0] fd_left  [TABLE_DEPTH];
	logic [FIELD_W-1:0] fd_right [TABLE_DEPTH];
	int unsigned        fd_used   = 0;
	logic [FIELD_W-1:0] rel_attrs = ALL_ATTRS;

	result_t  pending_results [$];
	dir_row_t dir_tab [N_DIRECTED];
	int       mismatches = 0;
	longint   cycle_cnt  = 0;
	logic     no_idle    = 1'b0;

	attribute_closure_engine_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.lhs_mask      (lhs_mask),
		.rhs_mask      (rhs_mask),
		.query_mask    (query_mask),
		.done          (done),
		.closure_mask  (closure_mask),
		.is_superkey   (is_superkey),
		.table_overflow(table_overflow),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [FIELD_W-1:0] fd_closure(input logic [FIELD_W-1:0] seed);
		logic [FIELD_W-1:0] cl;
		logic               grew;
		cl   = seed;
		grew = 1'b1;
		while (grew) begin
			grew = 1'b0;
			for (int i = 0; i < fd_used; i++) begin
				if ((fd_left[i] & ~cl) == '0 && (cl | fd_right[i]) != cl) begin
					cl   = cl | fd_right[i];
					grew = 1'b1;
				end
			end
		end
		return cl;
	endfunction

	// Applies one item to the table copy and returns the result it should give.
	function automatic result_t fd_process(input item_t it);
		result_t r;
		logic    hit;
		r   = '0;
		hit = 1'b0;
		if (it.cmd == CMD_LOAD) begin
			for (int i = 0; i < fd_used; i++) begin
				if (!hit && fd_left[i] == it.lhs) begin
					fd_right[i] = it.rhs;
					hit         = 1'b1;
				end
			end
			if (!hit) begin
				if (fd_used < TABLE_DEPTH) begin
					fd_left[fd_used]  = it.lhs;
					fd_right[fd_used] = it.rhs;
					fd_used++;
				end else begin
					r.overflow = 1'b1;
				end
			end
		end else begin
			r.closure  = fd_closure(it.qry);
			r.superkey = ((rel_attrs & ~r.closure) == '0);
		end
		return r;
	endfunction

	function automatic logic [FIELD_W-1:0] few_bits(input int n);
		logic [FIELD_W-1:0] m;
		m = '0;
		for (int i = 0; i < n; i++)
			m[$urandom_range(0, FIELD_W - 1)] = 1'b1;
		return m;
	endfunction

	// Mostly sparse sets, so that closures grow along chains over several passes.
	// Once the table is full, most loads rewrite a stored left set.
	function automatic item_t draw_item();
		item_t it;
		int    pick;
		it.cmd = $urandom_range(0, 1) ? CMD_QUERY : CMD_LOAD;
		it.lhs = FIELD_W'($urandom);
		it.rhs = FIELD_W'($urandom);
		it.qry = FIELD_W'($urandom);
		pick   = $urandom_range(0, 99);
		if (it.cmd == CMD_LOAD) begin
			if (fd_used != 0 && pick < (fd_used == TABLE_DEPTH ? 85 : 40))
				it.lhs = fd_left[$urandom_range(0, fd_used - 1)];
			else if (pick < 92)
				it.lhs = few_bits($urandom_range(0, 2));
			pick = $urandom_range(0, 99);
			if (pick < 70)
				it.rhs = few_bits($urandom_range(1, 3));
			else if (pick < 75)
				it.rhs = NO_ATTRS;
			else if (pick < 80)
				it.rhs = ALL_ATTRS;
		end else begin
			if (pick < 60)
				it.qry = few_bits($urandom_range(1, 2));
			else if (pick < 70)
				it.qry = NO_ATTRS;
			else if (pick < 75)
				it.qry = ALL_ATTRS;
		end
		return it;
	endfunction

	// Start is left high after acceptance; it is lowered only when a gap follows,
	// so it never sees two assignments in one step. The gap is counted from the
	// cycle in which busy has fallen, so that the block really sits idle.
	task automatic issue(input item_t it, output result_t pred);
		int gap;
		if ($urandom_range(0, 39) == 0)
			no_idle = ~no_idle;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			start <= 1'b0;
			do @(posedge clk); while (busy);
			repeat (gap - 1) @(posedge clk);
		end
		start      <= 1'b1;
		cmd        <= it.cmd;
		lhs_mask   <= it.lhs;
		rhs_mask   <= it.rhs;
		query_mask <= it.qry;
		do @(posedge clk); while (busy);
		pred = fd_process(it);
	endtask

	task automatic write_attrs(input logic [FIELD_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		rel_attrs = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_result(input result_t r);
		pending_results = {pending_results, r};
	endtask

	always @(posedge clk) begin
		result_t want;
		if (done === 1'b1) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 40)
					$display("%0t: expected no item, got closure %h superkey %b overflow %b",
						$time, closure_mask, is_superkey, table_overflow);
			end else begin
				want = pending_results.pop_front();
				if (closure_mask !== want.closure) begin
					mismatches++;
					if (mismatches <= 40)
						$display("%0t: closure_mask expected %h got %h",
							$time, want.closure, closure_mask);
				end
				if (is_superkey !== want.superkey) begin
					mismatches++;
					if (mismatches <= 40)
						$display("%0t: is_superkey expected %b got %b",
							$time, want.superkey, is_superkey);
				end
				if (table_overflow !== want.overflow) begin
					mismatches++;
					if (mismatches <= 40)
						$display("%0t: table_overflow expected %b got %b",
							$time, want.overflow, table_overflow);
				end
			end
		end
	end

	initial begin
		item_t              it;
		result_t            r;
		logic [FIELD_W-1:0] attrs;

		// The stored order puts e->f, d->e, c->d after the entries that reach c,
		// so a query from the empty set needs several passes.
		dir_tab = '{
			'{1'b1, '{CMD_QUERY, ALL_ATTRS, ALL_ATTRS, NO_ATTRS}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b1, '{CMD_QUERY, NO_ATTRS, NO_ATTRS, ALL_ATTRS}, '{ALL_ATTRS, 1'b1, 1'b0}},
			'{1'b1, '{CMD_LOAD, NO_ATTRS, 26'h0000001, ALL_ATTRS}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b0, '{CMD_QUERY, ALL_ATTRS, ALL_ATTRS, NO_ATTRS}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b1, '{CMD_LOAD, ALL_ATTRS, ALL_ATTRS, NO_ATTRS}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b1, '{CMD_LOAD, 26'h0000001, 26'h0000002, NO_ATTRS}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b1, '{CMD_LOAD, 26'h0000002, 26'h0000004, NO_ATTRS}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b1, '{CMD_LOAD, 26'h0000010, 26'h0000020, NO_ATTRS}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b1, '{CMD_LOAD, 26'h0000008, 26'h0000010, NO_ATTRS}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b1, '{CMD_LOAD, 26'h0000004, 26'h0000008, NO_ATTRS}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b0, '{CMD_QUERY, NO_ATTRS, NO_ATTRS, NO_ATTRS}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b1, '{CMD_LOAD, NO_ATTRS, NO_ATTRS, ALL_ATTRS}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b0, '{CMD_QUERY, NO_ATTRS, NO_ATTRS, 26'h0000004}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b1, '{CMD_LOAD, 26'h0000001, ALL_ATTRS, NO_ATTRS}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b0, '{CMD_QUERY, ALL_ATTRS, ALL_ATTRS, 26'h0000001}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b0, '{CMD_QUERY, NO_ATTRS, NO_ATTRS, 26'h3FFFFFE}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b0, '{CMD_QUERY, NO_ATTRS, NO_ATTRS, 26'h2000000}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b1, '{CMD_LOAD, 26'h2000000, 26'h0000001, ALL_ATTRS}, '{NO_ATTRS, 1'b0, 1'b0}},
			'{1'b0, '{CMD_QUERY, ALL_ATTRS, ALL_ATTRS, 26'h2000000}, '{NO_ATTRS, 1'b0, 1'b0}}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[k]) begin
			issue(dir_tab[k].it, r);
			queue_result(dir_tab[k].typed ? dir_tab[k].want : r);
		end
		start <= 1'b0;

		for (int ph = 0; ph < N_PHASES; ph++) begin
			while (pending_results.size() != 0) @(posedge clk);
			case (ph)
				0: attrs = NO_ATTRS;
				1: attrs = ALL_ATTRS;
				2: attrs = 26'h0000001;
				3: attrs = 26'h2000000;
				4: attrs = few_bits(3);
				5: attrs = FIELD_W'($urandom);
				6: attrs = few_bits(6);
				default: attrs = ALL_ATTRS;
			endcase
			write_attrs(attrs);
			repeat (ITEMS_PER_PHASE) begin
				it = draw_item();
				issue(it, r);
				queue_result(r);
			end
			start <= 1'b0;
		end

		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
